// ----- rtl/core/ple_pkg.sv -----
// shared types and constants for the positional list engine
package ple_pkg;
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int LEN_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_ERASE  = 3'd1,
        CMD_FIND   = 3'd2,
        CMD_READ   = 3'd3,
        CMD_WRITE  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RES,
        OP_INS_RD,
        OP_INS_WR,
        OP_INS_PUT,
        OP_ERA_RD,
        OP_ERA_WR,
        OP_ERA_END,
        OP_FND_RD,
        OP_FND_CMP,
        OP_RD,
        OP_RD_RES,
        OP_WR
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_INS_CHK,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_ERA_CHK,
        S_ERA_RD,
        S_ERA_WR,
        S_FND_CHK,
        S_FND_CMP,
        S_RD_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op     op;
        t_status status;
    } t_dp_ctl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       full;
        logic       pos_ok;
        logic       ins_more;
        logic       era_more;
        logic       fnd_more;
        logic       hit;
    } t_dp_sts;
endpackage

// ----- rtl/core/ple_dp.sv -----
// datapath: entry memory, length, scan index and result registers
module ple_dp import ple_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_ctl               i_ctl,
    input  logic [2:0]            i_command,
    input  logic [LEN_W-1:0]      i_position,
    input  logic [LEN_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_value,
    output t_dp_sts               o_sts,
    output logic [1:0]            o_status,
    output logic                  o_found,
    output logic [ADDR_W-1:0]     o_found_index,
    output logic [DATA_WIDTH-1:0] o_read_value,
    output logic [LEN_W-1:0]      o_length
);
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [2:0]            r_cmd;
    logic [LEN_W-1:0]      r_pos, n_pos;
    logic [LEN_W-1:0]      r_cnt, n_cnt;
    logic [LEN_W-1:0]      r_idx, n_idx;
    logic [DATA_WIDTH-1:0] r_val;
    logic [LEN_W-1:0]      r_len;
    logic [1:0]            r_status;
    logic                  r_found;
    logic [ADDR_W-1:0]     r_found_index;
    logic [DATA_WIDTH-1:0] r_read_value;
    logic [LEN_W:0]        era_src;
    logic [LEN_W-1:0]      tail;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [LEN_W-1:0]      raddr;

    assign era_src = {1'b0, r_idx} + {1'b0, r_cnt};
    assign tail    = r_len - i_position;

    always_comb begin
        n_pos = i_position;
        n_cnt = i_count;
        n_idx = '0;
        unique case (i_command)
            CMD_INSERT: begin
                if (i_position > r_len) begin
                    n_pos = r_len;
                end
                n_idx = r_len;
            end
            CMD_ERASE: begin
                if (i_position < r_len && i_count > tail) begin
                    n_cnt = tail;
                end
                n_idx = i_position;
            end
            default: n_idx = '0;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_idx[ADDR_W-1:0];
        wdata = r_rdata;
        re    = 1'b0;
        raddr = r_idx;
        unique case (i_ctl.op)
            OP_INS_WR, OP_ERA_WR: we = 1'b1;
            OP_INS_PUT, OP_WR: begin
                we    = 1'b1;
                waddr = r_pos[ADDR_W-1:0];
                wdata = r_val;
            end
            OP_INS_RD: begin
                re    = 1'b1;
                raddr = r_idx - LEN_W'(1);
            end
            OP_ERA_RD: begin
                re    = 1'b1;
                raddr = era_src[LEN_W-1:0];
            end
            OP_FND_RD: re = 1'b1;
            OP_RD: begin
                re    = 1'b1;
                raddr = r_pos;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr[ADDR_W-1:0]];
        end
        if (i_ctl.op == OP_LOAD) begin
            r_cmd <= i_command;
            r_pos <= n_pos;
            r_cnt <= n_cnt;
            r_val <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len         <= '0;
            r_idx         <= '0;
            r_status      <= ST_DONE;
            r_found       <= 1'b0;
            r_found_index <= '0;
            r_read_value  <= '0;
        end else begin
            unique case (i_ctl.op)
                OP_LOAD: begin
                    r_idx         <= n_idx;
                    r_status      <= ST_DONE;
                    r_found       <= 1'b0;
                    r_found_index <= '0;
                    r_read_value  <= '0;
                end
                OP_RES:     r_status <= i_ctl.status;
                OP_INS_WR:  r_idx <= r_idx - LEN_W'(1);
                OP_ERA_WR:  r_idx <= r_idx + LEN_W'(1);
                OP_INS_PUT: r_len <= r_len + LEN_W'(1);
                OP_ERA_END: r_len <= r_len - r_cnt;
                OP_FND_CMP: begin
                    if (o_sts.hit) begin
                        r_found       <= 1'b1;
                        r_found_index <= r_idx[ADDR_W-1:0];
                    end
                    r_idx <= r_idx + LEN_W'(1);
                end
                OP_RD_RES:  r_read_value <= r_rdata;
                default:    r_idx <= r_idx;
            endcase
        end
    end

    assign o_sts.cmd      = r_cmd;
    assign o_sts.full     = (r_len == LEN_W'(DEPTH));
    assign o_sts.pos_ok   = (r_pos < r_len);
    assign o_sts.ins_more = (r_idx > r_pos);
    assign o_sts.era_more = (era_src < {1'b0, r_len});
    assign o_sts.fnd_more = (r_idx < r_len);
    assign o_sts.hit      = (r_rdata == r_val);

    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_found_index = r_found_index;
    assign o_read_value  = r_read_value;
    assign o_length      = r_len;
endmodule

// ----- rtl/core/ple_ctrl.sv -----
// controller state machine sequencing each command
module ple_ctrl import ple_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_ctl o_ctl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DISP;
            S_DISP: begin
                unique case (i_sts.cmd)
                    CMD_INSERT: n_state = i_sts.full ? S_OUT : S_INS_CHK;
                    CMD_ERASE:  n_state = i_sts.pos_ok ? S_ERA_CHK : S_OUT;
                    CMD_FIND:   n_state = S_FND_CHK;
                    CMD_READ:   n_state = i_sts.pos_ok ? S_RD_WAIT : S_OUT;
                    default:    n_state = S_OUT;
                endcase
            end
            S_INS_CHK: n_state = i_sts.ins_more ? S_INS_RD : S_INS_PUT;
            S_INS_RD:  n_state = S_INS_WR;
            S_INS_WR:  n_state = S_INS_CHK;
            S_INS_PUT: n_state = S_OUT;
            S_ERA_CHK: n_state = i_sts.era_more ? S_ERA_RD : S_OUT;
            S_ERA_RD:  n_state = S_ERA_WR;
            S_ERA_WR:  n_state = S_ERA_CHK;
            S_FND_CHK: n_state = i_sts.fnd_more ? S_FND_CMP : S_OUT;
            S_FND_CMP: n_state = i_sts.hit ? S_OUT : S_FND_CHK;
            S_RD_WAIT: n_state = S_OUT;
            S_OUT:     if (i_out_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.op     = OP_NONE;
        o_ctl.status = ST_DONE;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctl.op = OP_LOAD;
            end
            S_DISP: begin
                unique case (i_sts.cmd)
                    CMD_INSERT: begin
                        if (i_sts.full) begin
                            o_ctl.op     = OP_RES;
                            o_ctl.status = ST_FULL;
                        end
                    end
                    CMD_ERASE, CMD_FIND: o_ctl.op = OP_NONE;
                    CMD_READ: begin
                        if (i_sts.pos_ok) begin
                            o_ctl.op = OP_RD;
                        end else begin
                            o_ctl.op     = OP_RES;
                            o_ctl.status = ST_RANGE;
                        end
                    end
                    CMD_WRITE: begin
                        if (i_sts.pos_ok) begin
                            o_ctl.op = OP_WR;
                        end else begin
                            o_ctl.op     = OP_RES;
                            o_ctl.status = ST_RANGE;
                        end
                    end
                    default: begin
                        o_ctl.op     = OP_RES;
                        o_ctl.status = ST_RANGE;
                    end
                endcase
            end
            S_INS_RD:  o_ctl.op = OP_INS_RD;
            S_INS_WR:  o_ctl.op = OP_INS_WR;
            S_INS_PUT: o_ctl.op = OP_INS_PUT;
            S_ERA_CHK: o_ctl.op = i_sts.era_more ? OP_NONE : OP_ERA_END;
            S_ERA_RD:  o_ctl.op = OP_ERA_RD;
            S_ERA_WR:  o_ctl.op = OP_ERA_WR;
            S_FND_CHK: if (i_sts.fnd_more) o_ctl.op = OP_FND_RD;
            S_FND_CMP: o_ctl.op = OP_FND_CMP;
            S_RD_WAIT: o_ctl.op = OP_RD_RES;
            S_OUT:     o_out_valid = 1'b1;
            default:   o_ctl.op = OP_NONE;
        endcase
    end
endmodule

// ----- rtl/core/positional_list_engine.sv -----
// top level of the positional list engine
// insert shifts the entries between position and end up one place, erase moves the
// entries behind the erased run down, find scans from index 0 to a hit or the end;
// one command in flight: a new one is taken only in idle, after the result is delivered
// reset (synchronous, active low) empties the list; entry contents stay undefined
module positional_list_engine import ple_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_command,
    input  logic [LEN_W-1:0]      i_position,
    input  logic [LEN_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic                  o_found,
    output logic [ADDR_W-1:0]     o_found_index,
    output logic [DATA_WIDTH-1:0] o_read_value,
    output logic [LEN_W-1:0]      o_length
);
    t_dp_ctl ctl;
    t_dp_sts sts;

    ple_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_ctl       (ctl)
    );

    ple_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_command     (i_command),
        .i_position    (i_position),
        .i_count       (i_count),
        .i_value       (i_value),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_read_value  (o_read_value),
        .o_length      (o_length)
    );

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("word held and new word taken at once");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_length <= LEN_W'(DEPTH)) else $error("length beyond capacity");
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> o_ready) else $error("not idle after delivery");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == ST_DONE)) else $error("hit with error status");
`endif
endmodule

// ----- bench/positional_list_engine_tb.sv -----
// testbench for the positional list engine: queued commands checked against a list predictor
`timescale 1ns / 1ps

module positional_list_engine_tb
    import ple_pkg::*;
();

    typedef struct {
        logic [2:0]            cmd;
        logic [LEN_W-1:0]      pos;
        logic [LEN_W-1:0]      cnt;
        logic [DATA_WIDTH-1:0] val;
    } t_list_cmd;

    typedef struct {
        logic [1:0]            status;
        logic                  found;
        logic [ADDR_W-1:0]     idx;
        logic [DATA_WIDTH-1:0] rdval;
        logic [LEN_W-1:0]      len;
    } t_list_resp;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [2:0]            i_command = '0;
    logic [LEN_W-1:0]      i_position = '0;
    logic [LEN_W-1:0]      i_count = '0;
    logic [DATA_WIDTH-1:0] i_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [1:0]            o_status;
    logic                  o_found;
    logic [ADDR_W-1:0]     o_found_index;
    logic [DATA_WIDTH-1:0] o_read_value;
    logic [LEN_W-1:0]      o_length;

    t_list_cmd  pending_cmds[$];
    t_list_resp expected_resps[$];
    logic [DATA_WIDTH-1:0] list_words[DEPTH];
    int list_len = 0;
    int mismatches = 0;
    int accepted_cnt = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int ready_mode = 0;
    int mode_left = 0;
    logic [DATA_WIDTH-1:0] value_pool[8];

    positional_list_engine uut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_list_resp apply_list_cmd(t_list_cmd c);
        t_list_resp r;
        int p;
        int n;
        r = '{status: ST_DONE, found: 1'b0, idx: '0, rdval: '0, len: '0};
        p = int'(c.pos);
        n = int'(c.cnt);
        case (c.cmd)
            CMD_INSERT: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (p > list_len) p = list_len;
                    for (int i = list_len; i > p; i--) begin
                        list_words[ADDR_W'(i)] = list_words[ADDR_W'(i-1)];
                    end
                    list_words[ADDR_W'(p)] = c.val;
                    list_len++;
                end
            end
            CMD_ERASE: begin
                if (p < list_len) begin
                    if (n > list_len - p) n = list_len - p;
                    for (int i = p; i + n < list_len; i++) begin
                        list_words[ADDR_W'(i)] = list_words[ADDR_W'(i+n)];
                    end
                    list_len -= n;
                end
            end
            CMD_FIND: begin
                for (int i = 0; i < list_len; i++) begin
                    if (!r.found && list_words[ADDR_W'(i)] == c.val) begin
                        r.found = 1'b1;
                        r.idx = ADDR_W'(i);
                    end
                end
            end
            CMD_READ: begin
                if (p < list_len) r.rdval = list_words[ADDR_W'(p)];
                else r.status = ST_RANGE;
            end
            CMD_WRITE: begin
                if (p < list_len) list_words[ADDR_W'(p)] = c.val;
                else r.status = ST_RANGE;
            end
            default: r.status = ST_RANGE;
        endcase
        r.len = LEN_W'(list_len);
        return r;
    endfunction

    task automatic queue_cmd(logic [2:0] cmd, int pos, int cnt, logic [DATA_WIDTH-1:0] val);
        t_list_cmd c;
        c.cmd = cmd;
        c.pos = LEN_W'(pos);
        c.cnt = LEN_W'(cnt);
        c.val = val;
        pending_cmds.push_back(c);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        if ($urandom_range(0, 1)) return value_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                t_list_cmd c;
                c.cmd = i_command;
                c.pos = i_position;
                c.cnt = i_count;
                c.val = i_value;
                expected_resps.push_back(apply_list_cmd(c));
                accepted_cnt++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0 || pending_cmds.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    t_list_cmd c;
                    c = pending_cmds.pop_front();
                    i_command <= c.cmd;
                    i_position <= c.pos;
                    i_count <= c.cnt;
                    i_value <= c.val;
                    i_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
            end
        end
    end

    // receiver stall pattern with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (!hold_done && accepted_cnt >= 300) begin
                hold_done = 1'b1;
                hold_left = 600;
            end
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 3) != 0);
                    default: i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_resps.size() == 0) begin
                report_mismatch("unexpected word", o_length, 0);
            end else begin
                t_list_resp e;
                e = expected_resps.pop_front();
                if (o_status !== e.status) report_mismatch("status", o_status, e.status);
                if (o_found !== e.found) report_mismatch("found", o_found, e.found);
                if (o_found_index !== e.idx) report_mismatch("found_index", o_found_index, e.idx);
                if (o_read_value !== e.rdval) report_mismatch("read_value", o_read_value, e.rdval);
                if (o_length !== e.len) report_mismatch("length", o_length, e.len);
            end
        end
    end

    initial begin
        #30ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int phase;
        int n;
        for (int i = 0; i < 8; i++) value_pool[i] = $urandom();
        value_pool[0] = '0;
        value_pool[1] = '1;

        queue_cmd(CMD_READ, 0, 0, '0);
        queue_cmd(CMD_ERASE, 0, 5, '0);
        queue_cmd(CMD_FIND, 0, 0, '0);
        queue_cmd(CMD_INSERT, 127, 0, '1);
        queue_cmd(CMD_INSERT, 0, 0, '0);
        queue_cmd(CMD_INSERT, 1, 0, 32'h5555_aaaa);
        queue_cmd(CMD_INSERT, 64, 0, 32'haaaa_5555);
        queue_cmd(CMD_READ, 0, 0, '0);
        queue_cmd(CMD_READ, 3, 0, '0);
        queue_cmd(CMD_READ, 127, 0, '0);
        queue_cmd(CMD_WRITE, 2, 0, 32'h1234_5678);
        queue_cmd(CMD_WRITE, 4, 0, '1);
        queue_cmd(CMD_FIND, 0, 0, 32'h1234_5678);
        queue_cmd(CMD_FIND, 0, 0, 32'hdead_beef);
        queue_cmd(CMD_ERASE, 1, 0, '0);
        queue_cmd(CMD_ERASE, 9, 1, '0);
        queue_cmd(3'd5, 0, 0, '0);
        queue_cmd(3'd7, 127, 127, '1);
        queue_cmd(CMD_ERASE, 1, 127, '0);
        queue_cmd(CMD_READ, 1, 0, '0);
        queue_cmd(CMD_ERASE, 0, 64, '0);

        n = 0;
        while (n < 1200) begin
            phase = $urandom_range(0, 3);
            repeat ($urandom_range(20, 90)) begin
                int r;
                logic [2:0] cmd;
                r = $urandom_range(0, 99);
                if (phase == 0) cmd = (r < 80) ? CMD_INSERT : CMD_FIND;
                else if (phase == 1) cmd = (r < 40) ? CMD_ERASE : (r < 70) ? CMD_FIND : CMD_READ;
                else if (r < 3) cmd = 3'($urandom_range(5, 7));
                else cmd = 3'($urandom_range(0, 4));
                queue_cmd(cmd,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(0, 66),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(0, 4),
                          pick_value());
                n++;
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_cmds.size() == 0 && !i_valid && expected_resps.size() == 0);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && expected_resps.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/ple_pkg.sv
rtl/core/ple_dp.sv
rtl/core/ple_ctrl.sv
rtl/core/positional_list_engine.sv
bench/positional_list_engine_tb.sv
